/* hw/rtl/vcpm_pkg.sv */
// shared types, codes and reset values for the velocity command priority mux
package vcpm_pkg;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_PLANNER_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_NAV_TIMEOUT     = 3'd1;
    localparam logic [2:0] REG_HEARTBEAT_LIMIT = 3'd2;
    localparam logic [2:0] REG_PUBLISH_PERIOD  = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED       = 3'd4;
    localparam logic [2:0] REG_MAX_TURN        = 3'd5;
    localparam logic [2:0] REG_ALLOW_REVERSE   = 3'd6;

    // register reset values
    localparam logic [15:0] RST_PLANNER_TIMEOUT = 16'd500;
    localparam logic [15:0] RST_NAV_TIMEOUT     = 16'd600;
    localparam logic [15:0] RST_HEARTBEAT_LIMIT = 16'd1500;
    localparam logic [9:0]  RST_PUBLISH_PERIOD  = 10'd33;
    localparam logic [14:0] RST_MAX_SPEED       = 15'd600;
    localparam logic [14:0] RST_MAX_TURN        = 15'd1200;
    localparam logic        RST_ALLOW_REVERSE   = 1'b0;

    // item actions
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_PLANNER = 2'd1;
    localparam logic [1:0] ACT_NAV     = 2'd2;
    localparam logic [1:0] ACT_SAFETY  = 2'd3;

    // result sources
    localparam logic [2:0] SRC_STOP           = 3'd0;
    localparam logic [2:0] SRC_HEARTBEAT_LOST = 3'd1;
    localparam logic [2:0] SRC_NAV            = 3'd2;
    localparam logic [2:0] SRC_PLANNER        = 3'd3;
    localparam logic [2:0] SRC_INPUT_TIMEOUT  = 3'd4;
    localparam logic [2:0] SRC_NONE           = 3'd5;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    // queue depths
    localparam int EVQ_DEPTH_DEF  = 2;
    localparam int RESQ_DEPTH_DEF = 2;

    typedef struct packed {
        logic [15:0] planner_timeout;
        logic [15:0] nav_timeout;
        logic [15:0] heartbeat_limit;
        logic [9:0]  publish_period;
        logic [14:0] max_speed;
        logic [14:0] max_turn;
        logic        allow_reverse;
    } cfg_t;

    // classified item from the front end
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] speed;
        logic signed [15:0] rate;
        logic               valid;
        logic               stop;
    } event_t;

    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] rate;
        logic [2:0]         source;
        logic               changed;
    } result_t;

endpackage

/* hw/rtl/vcpm_fifo.sv */
// small flop based first-in first-out queue
module vcpm_fifo #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/vcpm_regs.sv */
// configuration register file behind the apb-style port
module vcpm_regs import vcpm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_PLANNER_TIMEOUT: cfg_next.planner_timeout = pwdata[15:0];
                REG_NAV_TIMEOUT:     cfg_next.nav_timeout     = pwdata[15:0];
                REG_HEARTBEAT_LIMIT: cfg_next.heartbeat_limit = pwdata[15:0];
                REG_PUBLISH_PERIOD:  cfg_next.publish_period  = pwdata[9:0];
                REG_MAX_SPEED:       cfg_next.max_speed       = pwdata[14:0];
                REG_MAX_TURN:        cfg_next.max_turn        = pwdata[14:0];
                REG_ALLOW_REVERSE:   cfg_next.allow_reverse   = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PLANNER_TIMEOUT: prdata = {16'd0, cfg_reg.planner_timeout};
            REG_NAV_TIMEOUT:     prdata = {16'd0, cfg_reg.nav_timeout};
            REG_HEARTBEAT_LIMIT: prdata = {16'd0, cfg_reg.heartbeat_limit};
            REG_PUBLISH_PERIOD:  prdata = {22'd0, cfg_reg.publish_period};
            REG_MAX_SPEED:       prdata = {17'd0, cfg_reg.max_speed};
            REG_MAX_TURN:        prdata = {17'd0, cfg_reg.max_turn};
            REG_ALLOW_REVERSE:   prdata = {31'd0, cfg_reg.allow_reverse};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.planner_timeout <= RST_PLANNER_TIMEOUT;
            cfg_reg.nav_timeout     <= RST_NAV_TIMEOUT;
            cfg_reg.heartbeat_limit <= RST_HEARTBEAT_LIMIT;
            cfg_reg.publish_period  <= RST_PUBLISH_PERIOD;
            cfg_reg.max_speed       <= RST_MAX_SPEED;
            cfg_reg.max_turn        <= RST_MAX_TURN;
            cfg_reg.allow_reverse   <= RST_ALLOW_REVERSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/vcpm_front.sv */
// front end: sanitises, clamps and classifies each incoming item
module vcpm_front import vcpm_pkg::*; (
    input  cfg_t               cfg,
    input  logic [1:0]         action,
    input  logic signed [15:0] linear_speed,
    input  logic signed [15:0] turn_rate,
    input  logic               not_finite,
    input  logic               stop_request,
    output event_t             ev
);

    // symmetric clamp, a zero limit leaves the value alone
    function automatic logic signed [15:0] clamp_sym(
        input logic signed [15:0] v,
        input logic [14:0]        lim
    );
        logic signed [16:0] v_x;
        logic signed [16:0] pos_l;
        logic signed [16:0] neg_l;
        logic signed [15:0] r;
        v_x   = {v[15], v};
        pos_l = {2'b00, lim};
        neg_l = -pos_l;
        r     = v;
        if (lim != '0)
        begin
            if (v_x > pos_l)
            begin
                r = pos_l[15:0];
            end
            else if (v_x < neg_l)
            begin
                r = neg_l[15:0];
            end
        end
        return r;
    endfunction

    logic signed [15:0] speed_c;
    logic signed [15:0] rate_c;

    always_comb
    begin
        if (not_finite)
        begin
            speed_c = '0;
            rate_c  = '0;
        end
        else
        begin
            speed_c = clamp_sym(linear_speed, cfg.max_speed);
            rate_c  = clamp_sym(turn_rate, cfg.max_turn);
        end
        // planner reverse blocked unless allowed
        if (action == ACT_PLANNER && !cfg.allow_reverse && speed_c[15])
        begin
            speed_c = '0;
        end
        ev.action = action;
        ev.speed  = speed_c;
        ev.rate   = rate_c;
        ev.valid  = !not_finite;
        ev.stop   = stop_request;
    end

endmodule

/* hw/rtl/vcpm_back.sv */
// back end: source state, age counters, publish timer and priority choice
module vcpm_back import vcpm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  event_t  ev,
    input  logic    ev_avail,
    output logic    ev_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    logic signed [15:0] planner_speed_reg, planner_speed_next;
    logic signed [15:0] planner_rate_reg, planner_rate_next;
    logic signed [15:0] nav_speed_reg, nav_speed_next;
    logic signed [15:0] nav_rate_reg, nav_rate_next;
    logic [15:0]        planner_age_reg, planner_age_next;
    logic [15:0]        nav_age_reg, nav_age_next;
    logic [15:0]        safety_age_reg, safety_age_next;
    logic               planner_valid_reg, planner_valid_next;
    logic               nav_valid_reg, nav_valid_next;
    logic               safety_seen_reg, safety_seen_next;
    logic               stop_latched_reg, stop_latched_next;
    logic [9:0]         period_count_reg, period_count_next;
    logic [2:0]         last_source_reg, last_source_next;

    logic [15:0]        planner_age_inc;
    logic [15:0]        nav_age_inc;
    logic [15:0]        safety_age_inc;
    logic [9:0]         period_inc;
    logic               heartbeat_ok;
    logic               emit;
    logic [2:0]         emit_src;
    logic signed [15:0] emit_speed;
    logic signed [15:0] emit_rate;

    // one classified item per cycle whenever the result queue has room
    assign ev_pop = ev_avail && !res_full;

    assign planner_age_inc = (planner_age_reg == AGE_MAX) ? AGE_MAX : planner_age_reg + 16'd1;
    assign nav_age_inc     = (nav_age_reg == AGE_MAX) ? AGE_MAX : nav_age_reg + 16'd1;
    assign safety_age_inc  = (safety_age_reg == AGE_MAX) ? AGE_MAX : safety_age_reg + 16'd1;
    assign period_inc      = period_count_reg + 10'd1;

    assign heartbeat_ok = safety_seen_reg &&
        (cfg.heartbeat_limit == '0 || safety_age_inc <= cfg.heartbeat_limit);

    always_comb
    begin
        planner_speed_next = planner_speed_reg;
        planner_rate_next  = planner_rate_reg;
        nav_speed_next     = nav_speed_reg;
        nav_rate_next      = nav_rate_reg;
        planner_age_next   = planner_age_reg;
        nav_age_next       = nav_age_reg;
        safety_age_next    = safety_age_reg;
        planner_valid_next = planner_valid_reg;
        nav_valid_next     = nav_valid_reg;
        safety_seen_next   = safety_seen_reg;
        stop_latched_next  = stop_latched_reg;
        period_count_next  = period_count_reg;
        emit       = 1'b0;
        emit_src   = SRC_INPUT_TIMEOUT;
        emit_speed = '0;
        emit_rate  = '0;
        if (ev_pop)
        begin
            case (ev.action)
                ACT_TICK:
                begin
                    planner_age_next = planner_age_inc;
                    nav_age_next     = nav_age_inc;
                    safety_age_next  = safety_age_inc;
                    if (period_inc == '0 || period_inc >= cfg.publish_period)
                    begin
                        period_count_next = '0;
                        emit = 1'b1;
                        // priority on the ages after this tick
                        if (stop_latched_reg)
                        begin
                            emit_src = SRC_STOP;
                        end
                        else if (!heartbeat_ok)
                        begin
                            emit_src = SRC_HEARTBEAT_LOST;
                        end
                        else if (nav_valid_reg && nav_age_inc <= cfg.nav_timeout)
                        begin
                            emit_src   = SRC_NAV;
                            emit_speed = nav_speed_reg;
                            emit_rate  = nav_rate_reg;
                        end
                        else if (planner_valid_reg && planner_age_inc <= cfg.planner_timeout)
                        begin
                            emit_src   = SRC_PLANNER;
                            emit_speed = planner_speed_reg;
                            emit_rate  = planner_rate_reg;
                        end
                        else
                        begin
                            emit_src = SRC_INPUT_TIMEOUT;
                        end
                    end
                    else
                    begin
                        period_count_next = period_inc;
                    end
                end
                ACT_PLANNER:
                begin
                    planner_speed_next = ev.speed;
                    planner_rate_next  = ev.rate;
                    planner_age_next   = '0;
                    planner_valid_next = ev.valid;
                end
                ACT_NAV:
                begin
                    nav_speed_next = ev.speed;
                    nav_rate_next  = ev.rate;
                    nav_age_next   = '0;
                    nav_valid_next = ev.valid;
                end
                default:
                begin
                    stop_latched_next = ev.stop;
                    safety_age_next   = '0;
                    safety_seen_next  = 1'b1;
                    if (ev.stop)
                    begin
                        emit     = 1'b1;
                        emit_src = SRC_STOP;
                    end
                end
            endcase
        end
        last_source_next = emit ? emit_src : last_source_reg;
    end

    assign res_push    = emit;
    assign res.speed   = emit_speed;
    assign res.rate    = emit_rate;
    assign res.source  = emit_src;
    assign res.changed = (emit_src != last_source_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planner_speed_reg <= '0;
            planner_rate_reg  <= '0;
            nav_speed_reg     <= '0;
            nav_rate_reg      <= '0;
            planner_age_reg   <= AGE_MAX;
            nav_age_reg       <= AGE_MAX;
            safety_age_reg    <= AGE_MAX;
            planner_valid_reg <= 1'b0;
            nav_valid_reg     <= 1'b0;
            safety_seen_reg   <= 1'b0;
            stop_latched_reg  <= 1'b0;
            period_count_reg  <= '0;
            last_source_reg   <= SRC_NONE;
        end
        else
        begin
            planner_speed_reg <= planner_speed_next;
            planner_rate_reg  <= planner_rate_next;
            nav_speed_reg     <= nav_speed_next;
            nav_rate_reg      <= nav_rate_next;
            planner_age_reg   <= planner_age_next;
            nav_age_reg       <= nav_age_next;
            safety_age_reg    <= safety_age_next;
            planner_valid_reg <= planner_valid_next;
            nav_valid_reg     <= nav_valid_next;
            safety_seen_reg   <= safety_seen_next;
            stop_latched_reg  <= stop_latched_next;
            period_count_reg  <= period_count_next;
            last_source_reg   <= last_source_next;
        end
    end

endmodule

/* hw/rtl/velocity_command_priority_mux_unit.sv */
// top level of the velocity command priority mux
// data path: an accepted item is stored in the event queue, whose head the back end
// reads; its result, if any, goes into the result queue, whose head drives the ports
// throughput: one item per cycle, bounded by the single back end state update per cycle
// and by room in the two-entry result queue when the consumer stalls
// reset: asynchronous active low; both queues empty, registers at their defaults,
// ages saturated and no previous source; no clearing pass, items are taken at once
module velocity_command_priority_mux_unit import vcpm_pkg::*; #(
    parameter int EVQ_DEPTH  = EVQ_DEPTH_DEF,
    parameter int RESQ_DEPTH = RESQ_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // item input, queue style
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic signed [15:0] linear_speed,
    input  logic signed [15:0] turn_rate,
    input  logic               not_finite,
    input  logic               stop_request,
    // result output, queue style
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] out_linear_speed,
    output logic signed [15:0] out_turn_rate,
    output logic [2:0]         source,
    output logic               source_changed,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t    cfg;
    event_t  ev_in;
    event_t  ev_head;
    result_t res_in;
    result_t res_head;
    logic    ev_empty;
    logic    ev_pop;
    logic    res_full;
    logic    res_push;

    // register file; the user must write it only while the block is idle, the block does not enforce this
    vcpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end: non-finite zeroing, symmetric clamps, planner reverse block
    vcpm_front u_front (
        .cfg          (cfg),
        .action       (action),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .not_finite   (not_finite),
        .stop_request (stop_request),
        .ev           (ev_in)
    );

    // event queue between front and back; full is the input back-pressure
    vcpm_fifo #(
        .WIDTH ($bits(event_t)),
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (ev_in),
        .full    (full),
        .pop     (ev_pop),
        .rd_data (ev_head),
        .empty   (ev_empty)
    );

    // back end: state update and priority choice, at most one result per item
    vcpm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .ev       (ev_head),
        .ev_avail (!ev_empty),
        .ev_pop   (ev_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // result queue; its head drives the result ports directly
    vcpm_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign out_linear_speed = res_head.speed;
    assign out_turn_rate    = res_head.rate;
    assign source           = res_head.source;
    assign source_changed   = res_head.changed;

endmodule

/* hw/rtl/vcpm_checker.sv */
// port level checks for the velocity command priority mux, bound to the top level
module vcpm_checker import vcpm_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] out_linear_speed,
    input logic signed [15:0] out_turn_rate,
    input logic [2:0]         source,
    input logic               source_changed
);

    logic [2:0] prev_src_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_src_reg <= SRC_NONE;
        end
        else if (pop && !empty)
        begin
            prev_src_reg <= source;
        end
    end

    a_source_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (source <= SRC_INPUT_TIMEOUT))
        else $error("result source out of range");

    a_zero_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (source == SRC_STOP || source == SRC_HEARTBEAT_LOST ||
                    source == SRC_INPUT_TIMEOUT))
        |-> (out_linear_speed == 16'sd0 && out_turn_rate == 16'sd0))
        else $error("stop or timeout result carries motion");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (source_changed == (source != prev_src_reg)))
        else $error("source changed flag disagrees with previous result");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(source) && $stable(out_linear_speed) &&
                              $stable(out_turn_rate)))
        else $error("stalled result did not hold");

endmodule

bind velocity_command_priority_mux_unit vcpm_checker u_vcpm_checker (.*);

/* test/tb_top.sv */
// self-checking testbench for the velocity command priority mux
module tb_top;
    import vcpm_pkg::*;

    // cycles without progress on either handshake before the run is declared hung; the
    // longest legitimate quiet stretch is the deliberate receiver hold-off
    localparam int IDLE_LIMIT    = 3000;
    // time allowed for the pipe to settle once every owed result has arrived
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         action;
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic               not_finite;
    logic               stop_request;
    logic               empty;
    logic               pop;
    logic signed [15:0] out_linear_speed;
    logic signed [15:0] out_turn_rate;
    logic [2:0]         source;
    logic               source_changed;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    velocity_command_priority_mux_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .action           (action),
        .linear_speed     (linear_speed),
        .turn_rate        (turn_rate),
        .not_finite       (not_finite),
        .stop_request     (stop_request),
        .empty            (empty),
        .pop              (pop),
        .out_linear_speed (out_linear_speed),
        .out_turn_rate    (out_turn_rate),
        .source           (source),
        .source_changed   (source_changed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // mirror of the register file, kept in step with every write
    cfg_t cfg_model;

    // mirror of the mux state
    int          plan_spd;
    int          plan_rt;
    int          nav_spd;
    int          nav_rt;
    int          plan_age;
    int          nav_age;
    int          safe_age;
    bit          plan_ok;
    bit          nav_ok;
    bit          safe_seen;
    bit          stop_held;
    int          tick_count;
    logic [2:0]  prev_src;

    // outputs still owed by the block, oldest first
    result_t     pending_results[$];

    int errors;
    int items_sent;
    int results_checked;
    int results_predicted;
    int src_hits[5];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int idle_cycles;

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------------------

    // symmetric clamp, a zero limit leaves the value alone
    function automatic int clamp_to(int v, int lim);
        if (lim == 0)
        begin
            return v;
        end
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic int age_step(int a);
        return (a >= int'(AGE_MAX)) ? int'(AGE_MAX) : a + 1;
    endfunction

    function automatic void queue_result(int spd, int rt, logic [2:0] src);
        result_t r;
        r.speed   = spd[15:0];
        r.rate    = rt[15:0];
        r.source  = src;
        r.changed = (src != prev_src);
        prev_src  = src;
        pending_results.push_back(r);
        results_predicted++;
    endfunction

    // pick the output by priority from the current ages and stored commands
    function automatic void choose_output();
        bit heartbeat_ok;
        heartbeat_ok = safe_seen &&
            (cfg_model.heartbeat_limit == 0 || safe_age <= int'(cfg_model.heartbeat_limit));
        if (stop_held)
            queue_result(0, 0, SRC_STOP);
        else if (!heartbeat_ok)
            queue_result(0, 0, SRC_HEARTBEAT_LOST);
        else if (nav_ok && nav_age <= int'(cfg_model.nav_timeout))
            queue_result(nav_spd, nav_rt, SRC_NAV);
        else if (plan_ok && plan_age <= int'(cfg_model.planner_timeout))
            queue_result(plan_spd, plan_rt, SRC_PLANNER);
        else
            queue_result(0, 0, SRC_INPUT_TIMEOUT);
    endfunction

    function automatic void predict_mux(logic [1:0] act, logic signed [15:0] spd_in,
                                        logic signed [15:0] rt_in, logic nf, logic stop_bit);
        int spd;
        int rt;
        if (nf)
        begin
            spd = 0;
            rt  = 0;
        end
        else
        begin
            spd = clamp_to(int'(spd_in), int'(cfg_model.max_speed));
            rt  = clamp_to(int'(rt_in), int'(cfg_model.max_turn));
        end
        case (act)
            ACT_TICK:
            begin
                plan_age   = age_step(plan_age);
                nav_age    = age_step(nav_age);
                safe_age   = age_step(safe_age);
                tick_count = (tick_count + 1) & 10'h3FF;
                // a period of zero, or one lowered below the count, fires at once
                if (tick_count == 0 || tick_count >= int'(cfg_model.publish_period))
                begin
                    tick_count = 0;
                    choose_output();
                end
            end
            ACT_PLANNER:
            begin
                if (!cfg_model.allow_reverse && spd < 0)
                begin
                    spd = 0;
                end
                plan_spd = spd;
                plan_rt  = rt;
                plan_age = 0;
                plan_ok  = !nf;
            end
            ACT_NAV:
            begin
                nav_spd = spd;
                nav_rt  = rt;
                nav_age = 0;
                nav_ok  = !nf;
            end
            default:
            begin
                stop_held = stop_bit;
                safe_age  = 0;
                safe_seen = 1'b1;
                if (stop_bit)
                begin
                    queue_result(0, 0, SRC_STOP);
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------------------

    // filler for fields that the action ignores
    function automatic logic [15:0] rand_word();
        return 16'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    // offer one item and hold it until taken; push stays high on return so that
    // back-to-back items need no extra assignment in the same step
    task automatic send_item(input logic [1:0] act, input logic signed [15:0] spd,
                             input logic signed [15:0] rt, input logic nf,
                             input logic stop_bit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        action       <= act;
        linear_speed <= spd;
        turn_rate    <= rt;
        not_finite   <= nf;
        stop_request <= stop_bit;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        predict_mux(act, spd, rt, nf, stop_bit);
    endtask

    // stop offering, let every owed result arrive, then allow the pipe to settle
    task automatic wait_idle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers back to back, only ever called with the block idle
    task automatic load_config(input cfg_t c);
        logic [2:0]  idx;
        logic [31:0] v;
        for (int i = 0; i < 7; i++)
        begin
            idx = i[2:0];
            case (idx)
                REG_PLANNER_TIMEOUT: v = 32'(c.planner_timeout);
                REG_NAV_TIMEOUT:     v = 32'(c.nav_timeout);
                REG_HEARTBEAT_LIMIT: v = 32'(c.heartbeat_limit);
                REG_PUBLISH_PERIOD:  v = 32'(c.publish_period);
                REG_MAX_SPEED:       v = 32'(c.max_speed);
                REG_MAX_TURN:        v = 32'(c.max_turn);
                default:             v = 32'(c.allow_reverse);
            endcase
            // setup phase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'({idx, 2'b00});
            pwdata  <= v;
            @(posedge clk);
            // access phase
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cfg_model  = c;
    endtask

    // values spread over the whole field, around the clamp and at the very ends
    function automatic logic [15:0] pick_value(int lim);
        int v;
        case ($urandom_range(3))
            0:       v = $urandom;
            1:       v = int'($urandom_range(2 * lim + 2)) - lim - 1;
            2:       v = $urandom_range(1) ? 32767 : -32768;
            default: v = ($urandom_range(1) ? lim : -lim) + int'($urandom_range(2)) - 1;
        endcase
        return v[15:0];
    endfunction

    // mostly limits that ticks can cross quickly, sometimes the extremes
    function automatic int pick_limit(int lo, int hi, int top);
        case ($urandom_range(9))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic randomise_config();
        cfg_t c;
        c.planner_timeout = 16'(pick_limit(2, 40, 65535));
        c.nav_timeout     = 16'(pick_limit(2, 40, 65535));
        c.heartbeat_limit = 16'(pick_limit(5, 80, 65535));
        c.publish_period  = 10'(($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1));
        c.max_speed       = 15'(pick_limit(1, 3000, 32767));
        c.max_turn        = 15'(pick_limit(1, 3000, 32767));
        c.allow_reverse   = 1'($urandom_range(1));
        load_config(c);
    endtask

    // ticks dominate so that ages move; commands and safety traffic in between
    task automatic send_random_item();
        int         r;
        logic [1:0] act;
        logic       stop_bit;
        r   = $urandom_range(99);
        act = (r < 50) ? ACT_TICK : (r < 65) ? ACT_PLANNER : (r < 80) ? ACT_NAV : ACT_SAFETY;
        stop_bit = (act == ACT_SAFETY) ? ($urandom_range(9) < 3) : 1'($urandom_range(1));
        send_item(act, pick_value(int'(cfg_model.max_speed)),
                  pick_value(int'(cfg_model.max_turn)), $urandom_range(9) == 0, stop_bit);
    endtask

    // ---------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------

    // walk down the priority chain with the reset limits and a one tick period
    task automatic test_priority_order();
        cfg_t c;
        c = cfg_model;
        c.publish_period = 10'd1;
        load_config(c);
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit()); // no heartbeat
        send_item(ACT_SAFETY, rand_word(), rand_word(), rand_bit(), 1'b1);     // immediate stop
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit()); // stop held
        send_item(ACT_SAFETY, rand_word(), rand_word(), rand_bit(), 1'b0);     // stop cleared
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit()); // nothing fresh
        // reverse planner speed blocked, turn clamped
        send_item(ACT_PLANNER, 16'sh8000, 16'sd32767, 1'b0, rand_bit());
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        // navigation wins over planner, both axes clamped
        send_item(ACT_NAV, 16'sd32767, 16'sh8000, 1'b0, rand_bit());
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        // non-finite navigation falls back to the planner
        send_item(ACT_NAV, 16'sd32767, 16'sd32767, 1'b1, rand_bit());
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        // non-finite planner leaves nothing valid
        send_item(ACT_PLANNER, 16'sd300, -16'sd50, 1'b1, rand_bit());
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        send_item(ACT_SAFETY, rand_word(), rand_word(), 1'b1, 1'b1);
        wait_idle();
    endtask

    // zero and full-scale register values: no clamp, zero timeouts, zero period
    task automatic test_register_extremes();
        cfg_t c;
        c.planner_timeout = 16'd0;
        c.nav_timeout     = 16'hFFFF;
        c.heartbeat_limit = 16'd0;
        c.publish_period  = 10'd0;
        c.max_speed       = 15'd0;
        c.max_turn        = 15'h7FFF;
        c.allow_reverse   = 1'b1;
        load_config(c);
        send_item(ACT_SAFETY, rand_word(), rand_word(), rand_bit(), 1'b0);
        send_item(ACT_PLANNER, 16'sh8000, 16'sh8000, 1'b0, rand_bit());
        // planner already stale
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        send_item(ACT_NAV, 16'sh8000, 16'sd32767, 1'b0, rand_bit());
        // unclamped navigation
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        wait_idle();

        c.planner_timeout = 16'hFFFF;
        c.nav_timeout     = 16'd0;
        c.heartbeat_limit = 16'hFFFF;
        c.publish_period  = 10'd1;
        c.max_speed       = 15'h7FFF;
        c.max_turn        = 15'd0;
        c.allow_reverse   = 1'b0;
        load_config(c);
        send_item(ACT_PLANNER, -16'sd1, 16'sh8000, 1'b0, rand_bit());
        // planner, speed blocked
        send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        wait_idle();
    endtask

    // a period lowered below the running count fires on the very next tick
    task automatic test_period_reload();
        cfg_t c;
        c = cfg_model;
        c.publish_period = 10'd1023;
        load_config(c);
        repeat (5) send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        wait_idle();
        c.publish_period = 10'd3;
        load_config(c);
        repeat (2) send_item(ACT_TICK, rand_word(), rand_word(), rand_bit(), rand_bit());
        wait_idle();
    endtask

    // receiver holds off while items keep coming, so both queues fill and full rises
    task automatic test_backpressure();
        cfg_t c;
        c = cfg_model;
        c.publish_period = 10'd1;
        load_config(c);
        hold_left = HOLD_CYCLES;
        repeat (40) send_random_item();
        wait_idle();
    endtask

    // random traffic under each idling pattern and a couple of register settings each
    task automatic test_random_traffic();
        int start;
        int sent;
        for (int m = 0; m < 3; m++)
        begin
            case (m)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (2)
            begin
                randomise_config();
                start = results_predicted;
                sent  = 0;
                // keep going until enough results have been produced as well
                while (sent < 140 || results_predicted - start < 20)
                begin
                    send_random_item();
                    sent++;
                end
                wait_idle();
            end
        end
    endtask

    // ---------------------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------------------

    // receiver: a counted hold-off first, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // compare every accepted result with the oldest owed one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none owed, expected nothing, actual source %0d",
                         $time, source);
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("out_linear_speed", want.speed, out_linear_speed);
                report_field("out_turn_rate", want.rate, out_turn_rate);
                report_field("source", want.source, source);
                report_field("source_changed", want.changed, source_changed);
                if (source < 5)
                begin
                    src_hits[source]++;
                end
            end
        end
    end

    // watchdog on progress of either handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results still owed",
                         $time, idle_cycles, pending_results.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------------------

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        action       = ACT_TICK;
        linear_speed = '0;
        turn_rate    = '0;
        not_finite   = 1'b0;
        stop_request = 1'b0;
        pop          = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        // register and state mirrors at their reset values
        cfg_model.planner_timeout = RST_PLANNER_TIMEOUT;
        cfg_model.nav_timeout     = RST_NAV_TIMEOUT;
        cfg_model.heartbeat_limit = RST_HEARTBEAT_LIMIT;
        cfg_model.publish_period  = RST_PUBLISH_PERIOD;
        cfg_model.max_speed       = RST_MAX_SPEED;
        cfg_model.max_turn        = RST_MAX_TURN;
        cfg_model.allow_reverse   = RST_ALLOW_REVERSE;
        plan_spd   = 0;
        plan_rt    = 0;
        nav_spd    = 0;
        nav_rt     = 0;
        plan_age   = int'(AGE_MAX);
        nav_age    = int'(AGE_MAX);
        safe_age   = int'(AGE_MAX);
        plan_ok    = 1'b0;
        nav_ok     = 1'b0;
        safe_seen  = 1'b0;
        stop_held  = 1'b0;
        tick_count = 0;
        prev_src   = SRC_NONE;

        errors            = 0;
        items_sent        = 0;
        results_checked   = 0;
        results_predicted = 0;
        hold_left         = 0;
        idle_cycles       = 0;
        send_idle_pct     = 7;
        recv_idle_pct     = 71;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_priority_order();
        test_register_extremes();
        test_period_reload();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        $display("covered %0d items and %0d checked results over directed, back-pressure",
                 items_sent, results_checked);
        $display("and random phases; stop %0d, heartbeat lost %0d, nav %0d, planner %0d, %s %0d",
                 src_hits[0], src_hits[1], src_hits[2], src_hits[3], "input timeout",
                 src_hits[4]);
        if (errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
